FILE: sv/gta_pkg.sv
// gta_pkg: shared types and codes for the greedy track/cluster association block
// no dependencies; used by the interfaces, the track cell and the top level
`timescale 1ns / 1ps

package gta_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 16;
  localparam int IDX_W  = 4;
  localparam int SQD_W  = 34;

  localparam logic [OP_W-1:0] OP_LOAD_TRACK   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_CLUSTER = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN          = 2'd2;

  localparam logic [63:0] SQ_MAX = 64'h0000_0003_FFFF_FFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_OUT
  } state_t;

  // control flags of a search token travelling down the track chain
  typedef struct packed {
    logic wv;     // slot carries a cluster
    logic cval;   // cluster is loaded and still unused
    logic found;  // best fields hold a candidate
  } tok_ctl_t;

endpackage

FILE: sv/gta_in_if.sv
// gta_in_if: input channel (op, position) with valid/ready handshake
// depends on gta_pkg
`timescale 1ns / 1ps

interface gta_in_if;
  logic                               valid;
  logic                               ready;
  logic        [gta_pkg::OP_W-1:0]    op;
  logic signed [gta_pkg::POS_W-1:0]   pos_x;
  logic signed [gta_pkg::POS_W-1:0]   pos_y;

  modport source (output valid, op, pos_x, pos_y, input ready);
  modport sink (input valid, op, pos_x, pos_y, output ready);
endinterface

FILE: sv/gta_out_if.sv
// gta_out_if: result channel (one pair per transfer) with valid/ready handshake
// depends on gta_pkg
`timescale 1ns / 1ps

interface gta_out_if;
  logic                         valid;
  logic                         ready;
  logic [gta_pkg::IDX_W-1:0]    cluster_index;
  logic [gta_pkg::IDX_W-1:0]    track_index;
  logic [gta_pkg::SQD_W-1:0]    sq_distance;
  logic                         matched;
  logic                         overflow;
  logic                         last;

  modport source (output valid, cluster_index, track_index, sq_distance, matched,
                  overflow, last, input ready);
  modport sink (input valid, cluster_index, track_index, sq_distance, matched,
                overflow, last, output ready);
endinterface

FILE: sv/gta_cell.sv
// gta_cell: one track slot of the search chain; holds a track position and
// folds its distance to the passing cluster into the running best. depends on gta_pkg
`timescale 1ns / 1ps

module gta_cell #(
  parameter int CW  = 16,
  parameter int TIW = 4,
  parameter int CIW = 4,
  parameter int DW  = 35,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ld,
  input  logic signed [CW-1:0]    ld_x,
  input  logic signed [CW-1:0]    ld_y,
  input  logic                    trk_ok,
  input  gta_pkg::tok_ctl_t       ctl_i,
  input  logic signed [CW-1:0]    cx_i,
  input  logic signed [CW-1:0]    cy_i,
  input  logic [CIW-1:0]          cidx_i,
  input  logic [DW-1:0]           bd_i,
  input  logic [CIW-1:0]          bc_i,
  input  logic [TIW-1:0]          bt_i,
  output gta_pkg::tok_ctl_t       ctl_o,
  output logic signed [CW-1:0]    cx_o,
  output logic signed [CW-1:0]    cy_o,
  output logic [CIW-1:0]          cidx_o,
  output logic [DW-1:0]           bd_o,
  output logic [CIW-1:0]          bc_o,
  output logic [TIW-1:0]          bt_o
);

  logic signed [CW-1:0]   tx_r, ty_r;
  logic signed [CW:0]     dx, dy;
  logic signed [2*CW+1:0] px, py;
  logic [DW-1:0]          d;
  logic                   take;
  gta_pkg::tok_ctl_t      ctl_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      tx_r <= ld_x;
      ty_r <= ld_y;
    end
  end

  always_comb begin
    dx   = (CW+1)'(tx_r) - (CW+1)'(cx_i);
    dy   = (CW+1)'(ty_r) - (CW+1)'(cy_i);
    px   = dx * dx;
    py   = dy * dy;
    d    = DW'($unsigned(px)) + DW'($unsigned(py));
    // strict less keeps the lowest track on a tie
    take = ctl_i.wv && ctl_i.cval && trk_ok && (!ctl_i.found || d < bd_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.wv    <= ctl_i.wv;
      ctl_r.cval  <= ctl_i.cval;
      ctl_r.found <= ctl_i.found | take;
    end
  end

  always_ff @(posedge clk) begin
    cx_o   <= cx_i;
    cy_o   <= cy_i;
    cidx_o <= cidx_i;
    bd_o   <= take ? d : bd_i;
    bc_o   <= take ? cidx_i : bc_i;
    bt_o   <= take ? TIW'(IDX) : bt_i;
  end

  assign ctl_o = ctl_r;

endmodule

FILE: sv/greedy_track_cluster_association.sv
// channel  | dir | handshake     | payload
// in_ch    | in  | valid/ready   | op, pos_x, pos_y
// out_ch   | out | valid/ready   | cluster_index, track_index, sq_distance, matched,
//          |     |               | overflow, last
// a run emits min(tracks, clusters) results (or one no-match result); each pick
// streams every cluster slot through the chain of track cells, then the best pick
// moves into the output register.
// reset clears counts, used masks and the dropped flag; position stores need no reset.
// a stalled output holds the next pick; input is taken only between runs.
// depends on gta_pkg, gta_in_if, gta_out_if, gta_cell
`timescale 1ns / 1ps

module greedy_track_cluster_association #(
  parameter int MAX_TRACKS   = 16,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gta_in_if.sink    in_ch,
  gta_out_if.source out_ch
);

  localparam int CW  = COORD_WIDTH;
  localparam int MT  = MAX_TRACKS;
  localparam int MC  = MAX_CLUSTERS;
  localparam int TIW = (MT > 1) ? $clog2(MT) : 1;
  localparam int CIW = (MC > 1) ? $clog2(MC) : 1;
  localparam int TCW = $clog2(MT + 1);
  localparam int CCW = $clog2(MC + 1);
  localparam int DW  = 2 * CW + 3;
  localparam int NW  = $clog2(MC + MT + 2);
  localparam logic [NW-1:0] CNT_END = NW'(MC + MT + 1);

  gta_pkg::state_t state_r, state_nxt;

  logic [TCW-1:0] track_count_r;
  logic [CCW-1:0] cluster_count_r;
  logic [MT-1:0]  track_used_r;
  logic [MC-1:0]  cluster_used_r;
  logic           drop_r;
  logic [TCW-1:0] pairs_r, pick_r;
  logic           nomatch_r;
  logic [NW-1:0]  cnt_r;

  logic signed [CW-1:0] cl_x_mem [MC];
  logic signed [CW-1:0] cl_y_mem [MC];

  logic signed [CW-1:0] in_x, in_y;
  logic in_fire, run_go, ld_trk, ld_cl, load_out, is_last, search_done;
  logic [7:0] tc8, cc8;

  // injection stage
  logic                 inj_wv_r, inj_cval_r;
  logic signed [CW-1:0] inj_x_r, inj_y_r;
  logic [CIW-1:0]       inj_c_r;

  // chain wiring, index 0 is the injection stage
  gta_pkg::tok_ctl_t    ctl_c  [MT+1];
  logic signed [CW-1:0] cx_c   [MT+1];
  logic signed [CW-1:0] cy_c   [MT+1];
  logic [CIW-1:0]       cidx_c [MT+1];
  logic [DW-1:0]        bd_c   [MT+1];
  logic [CIW-1:0]       bc_c   [MT+1];
  logic [TIW-1:0]       bt_c   [MT+1];

  // global best of the current pick
  logic           g_found_r;
  logic [DW-1:0]  g_d_r;
  logic [CIW-1:0] g_c_r;
  logic [TIW-1:0] g_t_r;

  logic           out_valid_r;
  logic [63:0]    d_ext;

  assign in_x    = CW'(in_ch.pos_x);
  assign in_y    = CW'(in_ch.pos_y);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign ld_trk  = in_fire && (in_ch.op == gta_pkg::OP_LOAD_TRACK);
  assign ld_cl   = in_fire && (in_ch.op == gta_pkg::OP_LOAD_CLUSTER);
  assign run_go  = in_fire && (in_ch.op == gta_pkg::OP_RUN);
  assign tc8     = 8'(track_count_r);
  assign cc8     = 8'(cluster_count_r);
  assign search_done = (cnt_r == CNT_END);
  assign load_out = (state_r == gta_pkg::S_OUT) && (!out_valid_r || out_ch.ready);
  assign is_last  = nomatch_r || ((pick_r + TCW'(1)) == pairs_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gta_pkg::S_IDLE: begin
        if (run_go) begin
          state_nxt = (tc8 == 8'd0 || cc8 == 8'd0) ? gta_pkg::S_OUT : gta_pkg::S_SEARCH;
        end
      end
      gta_pkg::S_SEARCH: begin
        if (search_done) state_nxt = gta_pkg::S_OUT;
      end
      gta_pkg::S_OUT: begin
        if (load_out) state_nxt = is_last ? gta_pkg::S_IDLE : gta_pkg::S_SEARCH;
      end
      default: state_nxt = gta_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    unique case (state_r)
      gta_pkg::S_IDLE:   in_ch.ready = 1'b1;
      gta_pkg::S_SEARCH: in_ch.ready = 1'b0;
      gta_pkg::S_OUT:    in_ch.ready = 1'b0;
      default:           in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= gta_pkg::S_IDLE;
      track_count_r   <= '0;
      cluster_count_r <= '0;
      track_used_r    <= '0;
      cluster_used_r  <= '0;
      drop_r          <= 1'b0;
      pairs_r         <= '0;
      pick_r          <= '0;
      nomatch_r       <= 1'b0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == gta_pkg::S_SEARCH) ? cnt_r + NW'(1) : '0;
      if (ld_trk) begin
        if (tc8 < 8'(MT)) track_count_r <= track_count_r + TCW'(1);
        else              drop_r <= 1'b1;
      end
      if (ld_cl) begin
        if (cc8 < 8'(MC)) cluster_count_r <= cluster_count_r + CCW'(1);
        else              drop_r <= 1'b1;
      end
      if (run_go) begin
        pairs_r   <= TCW'((tc8 < cc8) ? tc8 : cc8);
        pick_r    <= '0;
        nomatch_r <= (tc8 == 8'd0 || cc8 == 8'd0);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        pick_r      <= pick_r + TCW'(1);
        if (is_last) begin
          track_count_r   <= '0;
          cluster_count_r <= '0;
          track_used_r    <= '0;
          cluster_used_r  <= '0;
          drop_r          <= 1'b0;
        end else begin
          track_used_r[g_t_r]   <= 1'b1;
          cluster_used_r[g_c_r] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cluster store
  always_ff @(posedge clk) begin
    if (ld_cl && cc8 < 8'(MC)) begin
      cl_x_mem[cluster_count_r[CIW-1:0]] <= in_x;
      cl_y_mem[cluster_count_r[CIW-1:0]] <= in_y;
    end
    if (NW'(MC) > cnt_r) begin
      inj_x_r <= cl_x_mem[cnt_r[CIW-1:0]];
      inj_y_r <= cl_y_mem[cnt_r[CIW-1:0]];
    end
    inj_c_r <= cnt_r[CIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_wv_r   <= 1'b0;
      inj_cval_r <= 1'b0;
    end else begin
      inj_wv_r   <= (state_r == gta_pkg::S_SEARCH) && (NW'(MC) > cnt_r);
      inj_cval_r <= (8'(cnt_r) < cc8) && !cluster_used_r[cnt_r[CIW-1:0]];
    end
  end

  always_comb begin
    ctl_c[0].wv    = inj_wv_r;
    ctl_c[0].cval  = inj_cval_r;
    ctl_c[0].found = 1'b0;
    cx_c[0]   = inj_x_r;
    cy_c[0]   = inj_y_r;
    cidx_c[0] = inj_c_r;
    bd_c[0]   = '0;
    bc_c[0]   = '0;
    bt_c[0]   = '0;
  end

  for (genvar i = 0; i < MT; i++) begin : g_cell
    gta_cell #(
      .CW (CW),
      .TIW(TIW),
      .CIW(CIW),
      .DW (DW),
      .IDX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ld    (ld_trk && (track_count_r == TCW'(i))),
      .ld_x  (in_x),
      .ld_y  (in_y),
      .trk_ok((TCW'(i) < track_count_r) && !track_used_r[i]),
      .ctl_i (ctl_c[i]),
      .cx_i  (cx_c[i]),
      .cy_i  (cy_c[i]),
      .cidx_i(cidx_c[i]),
      .bd_i  (bd_c[i]),
      .bc_i  (bc_c[i]),
      .bt_i  (bt_c[i]),
      .ctl_o (ctl_c[i+1]),
      .cx_o  (cx_c[i+1]),
      .cy_o  (cy_c[i+1]),
      .cidx_o(cidx_c[i+1]),
      .bd_o  (bd_c[i+1]),
      .bc_o  (bc_c[i+1]),
      .bt_o  (bt_c[i+1])
    );
  end

  // clusters leave the chain in index order, strict less keeps the lowest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_found_r <= 1'b0;
    end else if (state_r == gta_pkg::S_SEARCH && cnt_r == '0) begin
      g_found_r <= 1'b0;
    end else if (ctl_c[MT].wv && ctl_c[MT].found && (!g_found_r || bd_c[MT] < g_d_r)) begin
      g_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_c[MT].wv && ctl_c[MT].found && (!g_found_r || bd_c[MT] < g_d_r)) begin
      g_d_r <= bd_c[MT];
      g_c_r <= bc_c[MT];
      g_t_r <= bt_c[MT];
    end
  end

  assign d_ext = 64'(g_d_r);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.cluster_index <= nomatch_r ? '0 : gta_pkg::IDX_W'(g_c_r);
      out_ch.track_index   <= nomatch_r ? '0 : gta_pkg::IDX_W'(g_t_r);
      out_ch.sq_distance   <= nomatch_r ? '0 :
                              (d_ext > gta_pkg::SQ_MAX) ? '1 : d_ext[gta_pkg::SQD_W-1:0];
      out_ch.matched       <= !nomatch_r;
      out_ch.overflow      <= drop_r;
      out_ch.last          <= is_last;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gta_pkg::S_IDLE) |-> !in_ch.ready)
    else $error("input taken during a run");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tc8 <= 8'(MT)) && (cc8 <= 8'(MC)))
    else $error("store count beyond capacity");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && is_last) |=> (track_count_r == '0 && cluster_count_r == '0 && !drop_r))
    else $error("run did not clear the stores");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !nomatch_r) |-> g_found_r)
    else $error("pick emitted with no candidate");

endmodule

FILE: sim/tb_greedy_track_cluster_association.sv
// testbench for greedy_track_cluster_association: loads tracks and clusters, runs
// greedy pairing and checks each result against a built-in greedy predictor
// depends on gta_pkg, gta_in_if, gta_out_if and the block's rtl
`timescale 1ns / 1ps

module tb_greedy_track_cluster_association;

  typedef struct packed {
    logic [gta_pkg::IDX_W-1:0] cluster_index;
    logic [gta_pkg::IDX_W-1:0] track_index;
    logic [gta_pkg::SQD_W-1:0] sq_distance;
    logic                      matched;
    logic                      overflow;
    logic                      last;
  } pair_t;

  typedef struct {
    logic [gta_pkg::OP_W-1:0]  op;
    logic [gta_pkg::POS_W-1:0] x;
    logic [gta_pkg::POS_W-1:0] y;
    bit                        has_exp;
    pair_t                     exp;
  } row_t;

  localparam int NTRK = 16;
  localparam int NCLU = 16;
  localparam int WATCHDOG = 20000;
  localparam int LONG_STALL = 400;
  // selector with no meaning, the block ignores it
  localparam logic [gta_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  gta_in_if  in_ch ();
  gta_out_if out_ch ();

  greedy_track_cluster_association u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic signed [gta_pkg::POS_W-1:0] trk_x [NTRK];
  logic signed [gta_pkg::POS_W-1:0] trk_y [NTRK];
  logic signed [gta_pkg::POS_W-1:0] clu_x [NCLU];
  logic signed [gta_pkg::POS_W-1:0] clu_y [NCLU];
  int    n_trk, n_clu;
  bit    dropped;
  pair_t pending_pairs[$];
  row_t  dir_rows[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    hold_rx = 1'b0;
  bit    done = 1'b0;

  function automatic void enqueue_exp(pair_t r);
    pending_pairs.insert(pending_pairs.size(), r);
  endfunction

  function automatic void add_row(logic [gta_pkg::OP_W-1:0] op,
                                  logic [gta_pkg::POS_W-1:0] x,
                                  logic [gta_pkg::POS_W-1:0] y, bit has_exp, pair_t exp);
    row_t rw;
    rw.op = op;
    rw.x = x;
    rw.y = y;
    rw.has_exp = has_exp;
    rw.exp = exp;
    dir_rows.insert(dir_rows.size(), rw);
  endfunction

  function automatic logic [63:0] dist2(int t, int c);
    longint dx, dy;
    dx = longint'(trk_x[t]) - longint'(clu_x[c]);
    dy = longint'(trk_y[t]) - longint'(clu_y[c]);
    return dx * dx + dy * dy;
  endfunction

  // updates predictor state and queues the expected results of a run
  task automatic predict(input logic [gta_pkg::OP_W-1:0] op,
                         input logic [gta_pkg::POS_W-1:0] x,
                         input logic [gta_pkg::POS_W-1:0] y);
    int pairs, bc, bt;
    bit found;
    logic [63:0] best, d;
    bit tu [NTRK];
    bit cu [NCLU];
    pair_t r;
    if (op == gta_pkg::OP_LOAD_TRACK) begin
      if (n_trk < NTRK) begin
        trk_x[n_trk] = x; trk_y[n_trk] = y; n_trk++;
      end else dropped = 1'b1;
    end else if (op == gta_pkg::OP_LOAD_CLUSTER) begin
      if (n_clu < NCLU) begin
        clu_x[n_clu] = x; clu_y[n_clu] = y; n_clu++;
      end else dropped = 1'b1;
    end else if (op == gta_pkg::OP_RUN) begin
      pairs = (n_trk < n_clu) ? n_trk : n_clu;
      foreach (tu[i]) tu[i] = 0;
      foreach (cu[i]) cu[i] = 0;
      if (pairs == 0) begin
        r = '{'0, '0, '0, 1'b0, dropped, 1'b1};
        enqueue_exp(r);
      end
      for (int p = 0; p < pairs; p++) begin
        found = 0; best = 0; bc = 0; bt = 0;
        for (int c = 0; c < n_clu; c++) begin
          if (cu[c]) continue;
          for (int t = 0; t < n_trk; t++) begin
            if (tu[t]) continue;
            d = dist2(t, c);
            if (!found || d < best) begin
              found = 1; best = d; bc = c; bt = t;
            end
          end
        end
        cu[bc] = 1; tu[bt] = 1;
        r.cluster_index = gta_pkg::IDX_W'(bc);
        r.track_index = gta_pkg::IDX_W'(bt);
        r.sq_distance = (best > gta_pkg::SQ_MAX) ? gta_pkg::SQ_MAX[gta_pkg::SQD_W-1:0] :
                        best[gta_pkg::SQD_W-1:0];
        r.matched = 1'b1;
        r.overflow = dropped;
        r.last = (p + 1 == pairs);
        enqueue_exp(r);
      end
      n_trk = 0; n_clu = 0; dropped = 0;
    end
  endtask

  // valid stays high after a transfer until the next gap or idle_in
  task automatic send(input logic [gta_pkg::OP_W-1:0] op,
                      input logic [gta_pkg::POS_W-1:0] x,
                      input logic [gta_pkg::POS_W-1:0] y, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    predict(op, x, y);
  endtask

  task automatic idle_in();
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_rand(input logic [gta_pkg::OP_W-1:0] op);
    send(op, gta_pkg::POS_W'($urandom), gta_pkg::POS_W'($urandom),
         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
  endtask

  // coordinates clustered near each other so picks are close and ties happen
  task automatic send_near(input logic [gta_pkg::OP_W-1:0] op);
    logic [gta_pkg::POS_W-1:0] x, y;
    x = gta_pkg::POS_W'(int'($urandom_range(0, 15)) - 8);
    y = gta_pkg::POS_W'(int'($urandom_range(0, 15)) - 8);
    send(op, x, y, $urandom_range(0, 13));
  endtask

  function automatic logic [gta_pkg::POS_W-1:0] rnd_pos(bit near);
    if (near) return gta_pkg::POS_W'(int'($urandom_range(0, 15)) - 8);
    return gta_pkg::POS_W'($urandom);
  endfunction

  task automatic drain();
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    int wait_n;
    pair_t e;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        // long stretch with the receiver held off
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (wait_n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid);
        if (pending_pairs.size() == 0) begin
          $error("result with nothing expected: cluster %0d track %0d",
                 out_ch.cluster_index, out_ch.track_index);
          errors++;
        end else begin
          e = pending_pairs.pop_front();
          if (out_ch.cluster_index !== e.cluster_index) begin
            $error("cluster_index exp %0d got %0d", e.cluster_index, out_ch.cluster_index);
            errors++;
          end
          if (out_ch.track_index !== e.track_index) begin
            $error("track_index exp %0d got %0d", e.track_index, out_ch.track_index);
            errors++;
          end
          if (out_ch.sq_distance !== e.sq_distance) begin
            $error("sq_distance exp %0d got %0d", e.sq_distance, out_ch.sq_distance);
            errors++;
          end
          if (out_ch.matched !== e.matched) begin
            $error("matched exp %0b got %0b", e.matched, out_ch.matched);
            errors++;
          end
          if (out_ch.overflow !== e.overflow) begin
            $error("overflow exp %0b got %0b", e.overflow, out_ch.overflow);
            errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, out_ch.last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_rx)
      idle_cycles <= 0;
    else if (rst_n && !done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t rw;
    pair_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.op = gta_pkg::OP_LOAD_TRACK;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    n_trk = 0; n_clu = 0; dropped = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: empty run, extremes, ignored selector, single pair at max distance, tie
    add_row(gta_pkg::OP_RUN, 16'h0, 16'h0, 1, '{4'd0, 4'd0, 34'd0, 1'b0, 1'b0, 1'b1});
    add_row(OP_IGNORED, 16'h1234, 16'h5678, 0, none);
    add_row(gta_pkg::OP_LOAD_TRACK, 16'h7FFF, 16'h7FFF, 0, none);
    add_row(gta_pkg::OP_RUN, 16'hFFFF, 16'hFFFF, 1,
            '{4'd0, 4'd0, 34'd0, 1'b0, 1'b0, 1'b1});
    add_row(gta_pkg::OP_LOAD_TRACK, 16'h7FFF, 16'h7FFF, 0, none);
    add_row(gta_pkg::OP_LOAD_CLUSTER, 16'h8000, 16'h8000, 0, none);
    // 2 * 65535^2
    add_row(gta_pkg::OP_RUN, 16'h0, 16'h0, 1,
            '{4'd0, 4'd0, 34'h1_FFFC_0002, 1'b1, 1'b0, 1'b1});
    add_row(gta_pkg::OP_LOAD_CLUSTER, 16'h0000, 16'h0000, 0, none);
    add_row(gta_pkg::OP_LOAD_CLUSTER, 16'h0000, 16'h0000, 0, none);
    add_row(gta_pkg::OP_LOAD_TRACK, 16'h0001, 16'h0000, 0, none);
    add_row(gta_pkg::OP_LOAD_TRACK, 16'h0000, 16'hFFFF, 0, none);
    add_row(gta_pkg::OP_RUN, 16'h0, 16'h0, 0, none);
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send(rw.op, rw.x, rw.y, $urandom_range(0, 13));
      // typed rows are checked against the table value
      if (rw.has_exp && pending_pairs.size() > 0)
        pending_pairs[pending_pairs.size() - 1] = rw.exp;
    end

    // store full: 17 tracks and 17 clusters, overflow set on every result
    for (int k = 0; k < 17; k++) send_rand(gta_pkg::OP_LOAD_TRACK);
    for (int k = 0; k < 17; k++) send_rand(gta_pkg::OP_LOAD_CLUSTER);
    send_rand(gta_pkg::OP_RUN);

    // long receiver stall while the sender keeps offering frames
    hold_rx = 1'b1;
    for (int f = 0; f < 4; f++) begin
      for (int k = 0; k < 3; k++) send_near(gta_pkg::OP_LOAD_TRACK);
      for (int k = 0; k < 3; k++) send_near(gta_pkg::OP_LOAD_CLUSTER);
      send_rand(gta_pkg::OP_RUN);
    end

    // sender pause until everything is drained
    idle_in();
    drain();

    // random frames: mostly well-formed, some noise, small sizes mostly
    for (int f = 0; f < 40; f++) begin
      int nt, nc;
      bit near;
      near = $urandom_range(0, 1);
      nt = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      while (nt > 0 || nc > 0) begin
        if (nt > 0 && (nc == 0 || $urandom_range(0, 1))) begin
          send(gta_pkg::OP_LOAD_TRACK, rnd_pos(near), rnd_pos(near), $urandom_range(0, 13));
          nt--;
        end else begin
          send(gta_pkg::OP_LOAD_CLUSTER, rnd_pos(near), rnd_pos(near),
               $urandom_range(0, 13));
          nc--;
        end
        if ($urandom_range(0, 19) == 0) send_rand(OP_IGNORED);
      end
      send_rand(gta_pkg::OP_RUN);
    end

    idle_in();
    drain();
    repeat (100) @(posedge clk);
    done = 1'b1;
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
